// ===== src/rasc_pkg.sv =====
`default_nettype none
package rasc_pkg;

    localparam int WORD_BITS = 32;
    localparam int WIDE_BITS = 2 * WORD_BITS + 1;
    localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef logic [WIDE_BITS-1:0] wide_t;

    // which value the shared units work on
    typedef enum logic [1:0] {
        SEL_A   = 2'd0,
        SEL_B   = 2'd1,
        SEL_RES = 2'd2
    } sel_t;

    typedef struct packed {
        logic load;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic div_num;
        logic store;
        logic mul_a;
        logic mul_b;
        logic mul_d;
        logic combine;
        logic finish;
        sel_t sel;
    } ctrl_t;

    typedef struct packed {
        logic zero_den;
        logic gcd_done;
        logic div_done;
        logic is_cmp;
    } stat_t;

endpackage
`default_nettype wire

// ===== src/rasc_datapath.sv =====
`default_nettype none
module rasc_datapath (
    input  wire logic                              clk,
    input  wire rasc_pkg::ctrl_t                   ctrl,
    output rasc_pkg::stat_t                        stat,
    input  wire logic [1:0]                        command,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] a_num,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] a_den,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] b_num,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] b_den,
    output logic signed [rasc_pkg::WORD_BITS-1:0]  res_num_d,
    output logic [rasc_pkg::WORD_BITS-2:0]         res_den_d,
    output logic                                   is_equal_d,
    output logic [1:0]                             status_d
);
    import rasc_pkg::*;

    localparam int W = WORD_BITS;

    logic [1:0]   cmd_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         an_neg_reg, bn_neg_reg;
    logic [W:0]   am_reg, adm_reg, bm_reg, bdm_reg;
    logic         rneg_reg;
    wide_t        rm_reg, rd_reg;
    wide_t        t1_reg, t2_reg, dd_reg;
    // gcd unit: binary-free remainder via shared divider
    wide_t        gx_reg, gy_reg;
    // divider
    wide_t        dq_reg, dr_reg, dv_reg;
    logic [CNT_BITS-1:0] dcnt_reg;
    wide_t        qn_reg;

    logic [W-1:0] neg_an, neg_ad, neg_bn, neg_bd;
    wide_t        cur_m, cur_d, rem_sh, rem_diff;

    assign neg_an = W'(0) - an_reg;
    assign neg_ad = W'(0) - ad_reg;
    assign neg_bn = W'(0) - bn_reg;
    assign neg_bd = W'(0) - bd_reg;

    always_comb
    begin
        case (ctrl.sel)
            SEL_A:
            begin
                cur_m = WIDE_BITS'(am_reg);
                cur_d = WIDE_BITS'(adm_reg);
            end
            SEL_B:
            begin
                cur_m = WIDE_BITS'(bm_reg);
                cur_d = WIDE_BITS'(bdm_reg);
            end
            default:
            begin
                cur_m = rm_reg;
                cur_d = rd_reg;
            end
        endcase
    end

    assign rem_sh   = {dr_reg[WIDE_BITS-2:0], dq_reg[WIDE_BITS-1]};
    assign rem_diff = rem_sh - dv_reg;

    assign stat.zero_den = (ad_reg == '0) || (bd_reg == '0);
    assign stat.gcd_done = (gy_reg == '0);
    assign stat.div_done = (dcnt_reg == CNT_BITS'(0));
    assign stat.is_cmp   = cmd_reg[1];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        if (ctrl.gcd_init)
        begin
            if (ctrl.sel == SEL_A)
            begin
                // split operands into sign/magnitude
                am_reg  <= an_reg[W-1] ? {1'b0, neg_an} : {1'b0, an_reg};
                adm_reg <= ad_reg[W-1] ? {1'b0, neg_ad} : {1'b0, ad_reg};
                bm_reg  <= bn_reg[W-1] ? {1'b0, neg_bn} : {1'b0, bn_reg};
                bdm_reg <= bd_reg[W-1] ? {1'b0, neg_bd} : {1'b0, bd_reg};
                an_neg_reg <= an_reg[W-1] ^ ad_reg[W-1];
                bn_neg_reg <= bn_reg[W-1] ^ bd_reg[W-1];
                gx_reg <= an_reg[W-1] ? WIDE_BITS'({1'b0, neg_an}) : WIDE_BITS'(an_reg);
                gy_reg <= ad_reg[W-1] ? WIDE_BITS'({1'b0, neg_ad}) : WIDE_BITS'(ad_reg);
            end
            else
            begin
                gx_reg <= cur_m;
                gy_reg <= cur_d;
            end
        end
        if (ctrl.div_init)
        begin
            dq_reg <= ctrl.gcd_step ? gx_reg : (ctrl.div_num ? cur_m : cur_d);
            dv_reg <= ctrl.gcd_step ? gy_reg : gx_reg;
            dr_reg <= '0;
            dcnt_reg <= CNT_BITS'(WIDE_BITS);
        end
        else if (ctrl.div_step)
        begin
            if (!rem_diff[WIDE_BITS-1])
            begin
                dr_reg <= rem_diff;
                dq_reg <= {dq_reg[WIDE_BITS-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= rem_sh;
                dq_reg <= {dq_reg[WIDE_BITS-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - CNT_BITS'(1);
        end
        else if (ctrl.gcd_step)
        begin
            // Euclid: (x, y) <- (y, x mod y)
            gx_reg <= gy_reg;
            gy_reg <= dr_reg;
        end
        if (ctrl.store)
        begin
            if (ctrl.div_num)
                qn_reg <= dq_reg;
            else
            begin
                // quotient of denominator; numerator quotient in qn_reg
                case (ctrl.sel)
                    SEL_A:
                    begin
                        am_reg  <= qn_reg[W:0];
                        adm_reg <= (qn_reg == '0) ? (W+1)'(1) : dq_reg[W:0];
                        an_neg_reg <= an_neg_reg && (qn_reg != '0);
                    end
                    SEL_B:
                    begin
                        bm_reg  <= qn_reg[W:0];
                        bdm_reg <= (qn_reg == '0) ? (W+1)'(1) : dq_reg[W:0];
                        bn_neg_reg <= bn_neg_reg && (qn_reg != '0);
                    end
                    default:
                    begin
                        rm_reg <= qn_reg;
                        rd_reg <= (qn_reg == '0) ? WIDE_BITS'(1) : dq_reg;
                        rneg_reg <= rneg_reg && (qn_reg != '0);
                    end
                endcase
            end
        end
        if (ctrl.mul_a)
            t1_reg <= WIDE_BITS'(am_reg[W-1:0] * bdm_reg[W-1:0]);
        if (ctrl.mul_b)
            t2_reg <= WIDE_BITS'(bm_reg[W-1:0] * adm_reg[W-1:0]);
        if (ctrl.mul_d)
            dd_reg <= WIDE_BITS'(adm_reg[W-1:0] * bdm_reg[W-1:0]);
        if (ctrl.combine)
        begin
            logic bneg;
            bneg = (cmd_reg == CMD_SUB) ? !bn_neg_reg : bn_neg_reg;
            rd_reg <= dd_reg;
            if (an_neg_reg == bneg)
            begin
                rm_reg <= t1_reg + t2_reg;
                rneg_reg <= an_neg_reg;
            end
            else if (t1_reg >= t2_reg)
            begin
                rm_reg <= t1_reg - t2_reg;
                rneg_reg <= an_neg_reg;
            end
            else
            begin
                rm_reg <= t2_reg - t1_reg;
                rneg_reg <= bneg;
            end
        end
    end

    // result formatting from registered state
    localparam wide_t HALF = WIDE_BITS'(1) << (W - 1);
    logic ovf;
    assign ovf = (rneg_reg ? (rm_reg > HALF) : (rm_reg >= HALF)) || (rd_reg >= HALF);

    always_comb
    begin
        res_num_d  = '0;
        res_den_d  = '0;
        is_equal_d = 1'b0;
        status_d   = ST_OK;
        if (stat.zero_den)
            status_d = ST_ZERO;
        else if (cmd_reg[1])
            is_equal_d = (an_neg_reg == bn_neg_reg) && (am_reg == bm_reg)
                         && (adm_reg == bdm_reg);
        else if (ovf)
            status_d = ST_OVF;
        else
        begin
            res_num_d = rneg_reg ? (W'(0) - rm_reg[W-1:0]) : rm_reg[W-1:0];
            res_den_d = rd_reg[W-2:0];
        end
    end

endmodule
`default_nettype wire

// ===== src/rasc_ctrl.sv =====
`default_nettype none
module rasc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output rasc_pkg::ctrl_t     ctrl,
    input  wire rasc_pkg::stat_t stat
);
    import rasc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_GINIT = 10'b0000000100,
        S_GDIV  = 10'b0000001000,
        S_GSTEP = 10'b0000010000,
        S_QN    = 10'b0000100000,
        S_QD    = 10'b0001000000,
        S_MUL   = 10'b0010000000,
        S_COMB  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    sel_t   sel_reg, sel_next;
    logic   run_reg, run_next;   // divider running
    logic   first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_A;
            run_reg   <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            run_reg   <= run_next;
            first_reg <= first_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        run_next   = run_reg;
        first_next = first_reg;
        ctrl       = '0;
        ctrl.sel   = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.load = start;
                if (start)
                begin
                    sel_next = SEL_A;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
                state_next = stat.zero_den ? S_DONE : S_GINIT;
            S_GINIT:
            begin
                ctrl.gcd_init = 1'b1;
                state_next = S_GDIV;
            end
            S_GDIV:
            begin
                if (stat.gcd_done)
                begin
                    run_next = 1'b0;
                    state_next = S_QN;
                end
                else
                begin
                    ctrl.gcd_step = 1'b1;
                    ctrl.div_init = 1'b1;
                    state_next = S_GSTEP;
                end
            end
            S_GSTEP:
            begin
                if (!stat.div_done)
                    ctrl.div_step = 1'b1;
                else
                begin
                    ctrl.gcd_step = 1'b1;
                    state_next = S_GDIV;
                end
            end
            S_QN:
            begin
                ctrl.div_num = 1'b1;
                if (!run_reg)
                begin
                    ctrl.div_init = 1'b1;
                    run_next = 1'b1;
                end
                else if (!stat.div_done)
                    ctrl.div_step = 1'b1;
                else
                begin
                    ctrl.store = 1'b1;
                    run_next = 1'b0;
                    state_next = S_QD;
                end
            end
            S_QD:
            begin
                if (!run_reg)
                begin
                    ctrl.div_init = 1'b1;
                    run_next = 1'b1;
                end
                else if (!stat.div_done)
                    ctrl.div_step = 1'b1;
                else
                begin
                    ctrl.store = 1'b1;
                    run_next = 1'b0;
                    case (sel_reg)
                        SEL_A:
                        begin
                            sel_next = SEL_B;
                            state_next = S_GINIT;
                        end
                        SEL_B:
                        begin
                            if (stat.is_cmp)
                                state_next = S_DONE;
                            else
                            begin
                                first_next = 1'b1;
                                state_next = S_MUL;
                            end
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_MUL:
            begin
                ctrl.mul_a = first_reg;
                ctrl.mul_b = !first_reg;
                ctrl.mul_d = !first_reg;
                first_next = 1'b0;
                if (!first_reg)
                    state_next = S_COMB;
            end
            S_COMB:
            begin
                ctrl.combine = 1'b1;
                sel_next = SEL_RES;
                state_next = S_GINIT;
            end
            S_DONE:
            begin
                ctrl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/rational_add_sub_compare.sv =====
// The run time from start to done is set by the Euclid loop; every remainder and
// both reduction quotients go through one shared 65-step restoring divider, one
// quotient bit per cycle. Zero denominators skip the divider and go from the check to done.
// Throughput: one transaction at a time; start is taken only while busy is low.
// done pulses for one cycle with the result; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) returns the controller to idle.
`default_nettype none
module rational_add_sub_compare (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        command,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] a_num,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] a_den,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] b_num,
    input  wire logic signed [rasc_pkg::WORD_BITS-1:0] b_den,
    output logic                                   done,
    output logic signed [rasc_pkg::WORD_BITS-1:0]  res_num,
    output logic [rasc_pkg::WORD_BITS-2:0]         res_den,
    output logic                                   is_equal,
    output logic [1:0]                             status
);
    import rasc_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic signed [WORD_BITS-1:0] num_d;
    logic [WORD_BITS-2:0]        den_d;
    logic                        eq_d;
    logic [1:0]                  st_d;

    rasc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    rasc_datapath u_dp (
        .clk        (clk),
        .ctrl       (ctrl),
        .stat       (stat),
        .command    (command),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .res_num_d  (num_d),
        .res_den_d  (den_d),
        .is_equal_d (eq_d),
        .status_d   (st_d)
    );

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.finish;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            res_num  <= num_d;
            res_den  <= den_d;
            is_equal <= eq_d;
            status   <= st_d;
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire
